>>> rtl/core/bffa_pkg.sv
// Shared types and constants for the bitmap first-free allocator.
// Used by the channel interfaces, the map word unit, the register port and the top level.
// No dependencies.
`default_nettype none

package bffa_pkg;

  localparam int WORD_BITS = 128;
  localparam int BIT_W     = 7;
  localparam int NUM_W     = 14;
  localparam int STAT_W    = 2;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  localparam logic [NUM_W-1:0] ENTRIES_RST = 14'd8192;

  localparam logic REG_ENTRIES = 1'b0;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK           = 2'd0,
    STATUS_FULL         = 2'd1,
    STATUS_ALREADY_FREE = 2'd2,
    STATUS_RANGE        = 2'd3
  } status_t;

  typedef enum logic {
    OP_FIND_SET = 1'b0,
    OP_CLEAR    = 1'b1
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             tail_en;
    logic [BIT_W:0]   tail_cnt;
    logic [BIT_W-1:0] bit_sel;
  } unit_ctl_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] bit_idx;
    logic             bit_val;
  } unit_res_t;

  typedef struct packed {
    logic             wr;
    logic [NUM_W-1:0] entries;
  } cfg_evt_t;

endpackage

`default_nettype wire

>>> rtl/core/bffa_if.sv
// Valid/ready channel interfaces for allocator requests and responses.
// Depends on bffa_pkg for field widths.
`default_nettype none

interface bffa_req_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [bffa_pkg::NUM_W-1:0]  entry_number;

  modport source (output valid, output kind, output entry_number, input ready);
  modport sink   (input valid, input kind, input entry_number, output ready);
endinterface

interface bffa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [bffa_pkg::NUM_W-1:0]  granted_number;
  logic [bffa_pkg::STAT_W-1:0] status;
  logic [bffa_pkg::NUM_W-1:0]  free_left;

  modport source (output valid, output granted_number, output status, output free_left,
                  input ready);
  modport sink   (input valid, input granted_number, input status, input free_left,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/bffa_map_ram.sv
// Single write port, single read port memory holding the usage map rows.
// Read data is registered. No package dependencies.
`default_nettype none

module bffa_map_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 128,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output      logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bffa_word_unit.sv
// Shared map word unit: finds the lowest free bit of a row, tests a bit, and
// builds the updated row. Depends on bffa_pkg.
`default_nettype none

module bffa_word_unit (
  input  wire logic [bffa_pkg::WORD_BITS-1:0] word,
  input  wire bffa_pkg::unit_ctl_t            ctl,
  output      bffa_pkg::unit_res_t            res,
  output      logic [bffa_pkg::WORD_BITS-1:0] new_word
);

  logic [bffa_pkg::WORD_BITS-1:0] used;
  logic [bffa_pkg::WORD_BITS-1:0] zeros;
  logic [bffa_pkg::WORD_BITS-1:0] lowest;
  logic [bffa_pkg::BIT_W-1:0]     idx;

  always_comb begin
    for (int b = 0; b < bffa_pkg::WORD_BITS; b++) begin
      used[b] = word[b] | (ctl.tail_en && ((bffa_pkg::BIT_W+1)'(b) >= ctl.tail_cnt));
    end
  end

  assign zeros  = ~used;
  assign lowest = zeros & (~zeros + 1'b1);

  always_comb begin
    idx = '0;
    for (int k = 0; k < bffa_pkg::BIT_W; k++) begin
      for (int b = 0; b < bffa_pkg::WORD_BITS; b++) begin
        idx[k] = idx[k] | (lowest[b] & (((b >> k) & 1) == 1));
      end
    end
  end

  always_comb begin
    res.found   = |zeros;
    res.bit_idx = idx;
    res.bit_val = word[ctl.bit_sel];
    unique case (ctl.op)
      bffa_pkg::OP_FIND_SET: new_word = word | lowest;
      bffa_pkg::OP_CLEAR:    new_word = word & ~(bffa_pkg::WORD_BITS'(1) << ctl.bit_sel);
      default:               new_word = word;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/bffa_apb_regs.sv
// APB-style configuration register holding the pool size.
// Depends on bffa_pkg; reports each pool write to the sequencer as an event.
`default_nettype none

module bffa_apb_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bffa_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [bffa_pkg::CFG_DW-1:0]  pwdata,
  output      logic [bffa_pkg::CFG_DW-1:0]  prdata,
  output      logic                         pready,
  output      bffa_pkg::cfg_evt_t           evt
);

  logic [bffa_pkg::NUM_W-1:0] entries_r;
  logic [bffa_pkg::NUM_W-1:0] entries_nxt;
  logic                       hit;

  assign pready = 1'b1;
  assign hit    = psel && penable && pwrite && (paddr[2] == bffa_pkg::REG_ENTRIES);

  assign entries_nxt = hit ? pwdata[bffa_pkg::NUM_W-1:0] : entries_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= bffa_pkg::ENTRIES_RST;
    end else begin
      entries_r <= entries_nxt;
    end
  end

  assign evt.wr      = hit;
  assign evt.entries = pwdata[bffa_pkg::NUM_W-1:0];

  assign prdata = (paddr[2] == bffa_pkg::REG_ENTRIES)
                ? bffa_pkg::CFG_DW'(entries_r) : '0;

endmodule

`default_nettype wire

>>> rtl/core/bitmap_first_free_allocator.sv
// Top level of the bitmap first-free allocator: sequencer, map memory and response register.
// Depends on bffa_pkg, bffa_if, bffa_map_ram, bffa_word_unit and bffa_apb_regs.
//
// The allocator keeps one usage bit per entry in a memory of 128-bit rows and takes one
// request at a time. An allocate reads one row per cycle through the single map read port
// and the shared word unit checks it, from row 0 until it finds a free bit or reaches the
// last row of the pool. A release reads the row of its entry and clears the bit if it is
// set; a release of an invalid number or an allocate on an empty pool reads no row. The
// response sits in an output register, so a new request is taken while it waits. Reset
// and every pool size write reformat the map: a count of rows written since then marks
// the rest of the map as free, so there is no clearing pass.
`default_nettype none

module bitmap_first_free_allocator #(
  parameter int MAX_ENTRIES = 8192
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  bffa_req_if.sink                         in_req,
  bffa_rsp_if.source                       out_rsp,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [bffa_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [bffa_pkg::CFG_DW-1:0] cfg_pwdata,
  output      logic [bffa_pkg::CFG_DW-1:0] cfg_prdata,
  output      logic                        cfg_pready
);

  localparam int ROWS = (MAX_ENTRIES + bffa_pkg::WORD_BITS - 1) / bffa_pkg::WORD_BITS;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int HW_W  = $clog2(ROWS + 1);
  localparam int NW    = bffa_pkg::NUM_W;
  localparam int BW    = bffa_pkg::BIT_W;
  localparam logic [NW-1:0] POOL_RST =
    (int'(bffa_pkg::ENTRIES_RST) < MAX_ENTRIES) ? bffa_pkg::ENTRIES_RST : NW'(MAX_ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REL,
    S_RESP
  } state_t;

  state_t                state_r, state_nxt;
  logic [ROW_W-1:0]      chk_row_r, chk_row_nxt;
  logic [BW-1:0]         bit_sel_r, bit_sel_nxt;
  logic [NW-1:0]         pool_r, pool_nxt;
  logic [NW-1:0]         free_r, free_nxt;
  logic [HW_W-1:0]       hw_r, hw_nxt;
  logic [NW-1:0]         res_grant_r, res_grant_nxt;
  bffa_pkg::status_t     res_status_r, res_status_nxt;
  logic                  out_vld_r, out_vld_nxt;
  logic [NW-1:0]         out_grant_r, out_grant_nxt;
  bffa_pkg::status_t     out_status_r, out_status_nxt;
  logic [NW-1:0]         out_free_r, out_free_nxt;

  bffa_pkg::cfg_evt_t    cfg_evt;
  bffa_pkg::unit_ctl_t   ctl;
  bffa_pkg::unit_res_t   ures;
  logic [bffa_pkg::WORD_BITS-1:0] rd_data;
  logic [bffa_pkg::WORD_BITS-1:0] eff_word;
  logic [bffa_pkg::WORD_BITS-1:0] upd_word;
  logic                  rd_en, wr_en;
  logic [ROW_W-1:0]      rd_addr;
  logic [ROW_W-1:0]      last_row;
  logic [NW-1:0]         pool_m1;
  logic [NW-1:0]         num_m1;
  logic [NW-1:0]         cfg_pool;
  logic                  in_fire;
  logic                  out_free_slot;
  logic                  num_bad;

  bffa_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .evt     (cfg_evt)
  );

  bffa_map_ram #(
    .DEPTH (ROWS),
    .WIDTH (bffa_pkg::WORD_BITS),
    .AW    (ROW_W)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (chk_row_r),
    .wr_data (upd_word),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bffa_word_unit u_unit (
    .word     (eff_word),
    .ctl      (ctl),
    .res      (ures),
    .new_word (upd_word)
  );

  assign in_req.ready  = (state_r == S_IDLE);
  assign in_fire       = in_req.valid && in_req.ready;
  assign out_free_slot = !out_vld_r || out_rsp.ready;

  assign pool_m1  = pool_r - 1'b1;
  assign last_row = ROW_W'(pool_m1 >> BW);
  assign num_m1   = in_req.entry_number - 1'b1;
  assign num_bad  = (in_req.entry_number == '0) || (in_req.entry_number > pool_r);
  assign cfg_pool = (int'(cfg_evt.entries) < MAX_ENTRIES) ? cfg_evt.entries : NW'(MAX_ENTRIES);

  assign eff_word = (HW_W'(chk_row_r) < hw_r) ? rd_data : '0;

  assign ctl.op       = (state_r == S_REL) ? bffa_pkg::OP_CLEAR : bffa_pkg::OP_FIND_SET;
  assign ctl.tail_en  = (state_r == S_SCAN) && (chk_row_r == last_row);
  assign ctl.tail_cnt = (pool_r[BW-1:0] == '0) ? (BW+1)'(bffa_pkg::WORD_BITS)
                                              : {1'b0, pool_r[BW-1:0]};
  assign ctl.bit_sel  = bit_sel_r;

  always_comb begin
    state_nxt      = state_r;
    chk_row_nxt    = chk_row_r;
    bit_sel_nxt    = bit_sel_r;
    pool_nxt       = pool_r;
    free_nxt       = free_r;
    hw_nxt         = hw_r;
    res_grant_nxt  = res_grant_r;
    res_status_nxt = res_status_r;
    out_vld_nxt    = out_vld_r && !out_rsp.ready;
    out_grant_nxt  = out_grant_r;
    out_status_nxt = out_status_r;
    out_free_nxt   = out_free_r;
    rd_en          = 1'b0;
    rd_addr        = chk_row_r + 1'b1;
    wr_en          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_grant_nxt = '0;
          if (in_req.kind == bffa_pkg::KIND_ALLOC) begin
            if (pool_r == '0) begin
              res_status_nxt = bffa_pkg::STATUS_FULL;
              state_nxt      = S_RESP;
            end else begin
              rd_en       = 1'b1;
              rd_addr     = '0;
              chk_row_nxt = '0;
              state_nxt   = S_SCAN;
            end
          end else begin
            if (num_bad) begin
              res_status_nxt = bffa_pkg::STATUS_RANGE;
              state_nxt      = S_RESP;
            end else begin
              rd_en       = 1'b1;
              rd_addr     = ROW_W'(num_m1 >> BW);
              chk_row_nxt = ROW_W'(num_m1 >> BW);
              bit_sel_nxt = num_m1[BW-1:0];
              state_nxt   = S_REL;
            end
          end
        end
      end
      S_SCAN: begin
        if (ures.found) begin
          wr_en          = 1'b1;
          res_grant_nxt  = NW'({chk_row_r, ures.bit_idx}) + 1'b1;
          res_status_nxt = bffa_pkg::STATUS_OK;
          if (free_r != '0) begin
            free_nxt = free_r - 1'b1;
          end
          if (HW_W'(chk_row_r) == hw_r) begin
            hw_nxt = hw_r + 1'b1;
          end
          state_nxt = S_RESP;
        end else if (chk_row_r == last_row) begin
          res_status_nxt = bffa_pkg::STATUS_FULL;
          state_nxt      = S_RESP;
        end else begin
          rd_en       = 1'b1;
          chk_row_nxt = chk_row_r + 1'b1;
        end
      end
      S_REL: begin
        if (!ures.bit_val) begin
          res_status_nxt = bffa_pkg::STATUS_ALREADY_FREE;
        end else begin
          wr_en          = 1'b1;
          res_status_nxt = bffa_pkg::STATUS_OK;
          if (free_r < pool_r) begin
            free_nxt = free_r + 1'b1;
          end
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free_slot) begin
          out_vld_nxt    = 1'b1;
          out_grant_nxt  = res_grant_r;
          out_status_nxt = res_status_r;
          out_free_nxt   = free_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_evt.wr) begin
      pool_nxt = cfg_pool;
      free_nxt = cfg_pool;
      hw_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pool_r    <= POOL_RST;
      free_r    <= POOL_RST;
      hw_r      <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pool_r    <= pool_nxt;
      free_r    <= free_nxt;
      hw_r      <= hw_nxt;
      out_vld_r <= out_vld_nxt;
    end
    chk_row_r    <= chk_row_nxt;
    bit_sel_r    <= bit_sel_nxt;
    res_grant_r  <= res_grant_nxt;
    res_status_r <= res_status_nxt;
    out_grant_r  <= out_grant_nxt;
    out_status_r <= out_status_nxt;
    out_free_r   <= out_free_nxt;
  end

  assign out_rsp.valid          = out_vld_r;
  assign out_rsp.granted_number = out_grant_r;
  assign out_rsp.status         = out_status_r;
  assign out_rsp.free_left      = out_free_r;

`ifndef SYNTHESIS
  a_free_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= pool_r)
    else $error("free count exceeds pool size");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_req.ready)
    else $error("request taken while a transaction is in progress");

  a_scan_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (chk_row_r <= last_row))
    else $error("scan passed the last row of the pool");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(hw_r) <= ROWS)
    else $error("written row count exceeds map depth");
`endif

endmodule

`default_nettype wire

>>> tb/tb_bitmap_first_free_allocator.sv
// Self-checking testbench for bitmap_first_free_allocator: directed table, then random phases.
// Depends on bffa_pkg, bffa_if and the allocator RTL; an in-line bitmap model predicts
// every response that the directed table does not give itself.
module tb_bitmap_first_free_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAP_DEPTH = 8192;
  localparam int NUM_DIR = 29;
  localparam int NUM_PH = 14;
  localparam int QUIET_FROM = 12;
  localparam int PRESS_PH = 4;
  localparam int HOLD_CYCLES = 300;
  localparam logic [bffa_pkg::CFG_AW-1:0] ENTRIES_ADDR =
    bffa_pkg::CFG_AW'(4 * int'(bffa_pkg::REG_ENTRIES));

  typedef struct packed {
    logic [bffa_pkg::NUM_W-1:0] granted;
    bffa_pkg::status_t          status;
    logic [bffa_pkg::NUM_W-1:0] free_left;
  } answer_t;

  typedef enum logic {
    ACT_REQ,
    ACT_CFG
  } row_act_t;

  typedef struct packed {
    row_act_t                   act;
    logic                       kind;
    logic [bffa_pkg::NUM_W-1:0] num;
    logic                       typed;
    logic [bffa_pkg::NUM_W-1:0] g;
    bffa_pkg::status_t          st;
    logic [bffa_pkg::NUM_W-1:0] fl;
  } dir_row_t;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_psel;
  logic                        cfg_penable;
  logic                        cfg_pwrite;
  logic [bffa_pkg::CFG_AW-1:0] cfg_paddr;
  logic [bffa_pkg::CFG_DW-1:0] cfg_pwdata;
  logic [bffa_pkg::CFG_DW-1:0] cfg_prdata;
  logic                        cfg_pready;

  bffa_req_if req_ch();
  bffa_rsp_if rsp_ch();

  bitmap_first_free_allocator DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (req_ch),
    .out_rsp     (rsp_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  bit      used_bits [MAP_DEPTH];
  int      pool_n;
  int      free_n;
  int      held [$];
  answer_t answers_due [$];
  int      errors = 0;
  bit      quiet = 1'b0;
  bit      hold_rsp = 1'b0;

  dir_row_t dir_tab [NUM_DIR] = '{
    '{ACT_REQ, bffa_pkg::KIND_ALLOC, 14'd0, 1'b1, 14'd1, bffa_pkg::STATUS_OK, 14'd8191},
    '{ACT_REQ, bffa_pkg::KIND_ALLOC, 14'd16383, 1'b1, 14'd2, bffa_pkg::STATUS_OK, 14'd8190},
    '{ACT_REQ, bffa_pkg::KIND_RELEASE, 14'd0, 1'b1, 14'd0, bffa_pkg::STATUS_RANGE, 14'd8190},
    '{ACT_REQ, bffa_pkg::KIND_RELEASE, 14'd8193, 1'b1, 14'd0, bffa_pkg::STATUS_RANGE,
      14'd8190},
    '{ACT_REQ, bffa_pkg::KIND_RELEASE, 14'd16383, 1'b1, 14'd0, bffa_pkg::STATUS_RANGE,
      14'd8190},
    '{ACT_REQ, bffa_pkg::KIND_RELEASE, 14'd3, 1'b1, 14'd0, bffa_pkg::STATUS_ALREADY_FREE,
      14'd8190},
    '{ACT_REQ, bffa_pkg::KIND_RELEASE, 14'd1, 1'b1, 14'd0, bffa_pkg::STATUS_OK, 14'd8191},
    '{ACT_REQ, bffa_pkg::KIND_ALLOC, 14'd0, 1'b1, 14'd1, bffa_pkg::STATUS_OK, 14'd8190},
    '{ACT_REQ, bffa_pkg::KIND_RELEASE, 14'd8192, 1'b1, 14'd0, bffa_pkg::STATUS_ALREADY_FREE,
      14'd8190},
    '{ACT_CFG, bffa_pkg::KIND_ALLOC, 14'd1, 1'b0, 14'd0, bffa_pkg::STATUS_OK, 14'd0},
    '{ACT_REQ, bffa_pkg::KIND_ALLOC, 14'd0, 1'b1, 14'd1, bffa_pkg::STATUS_OK, 14'd0},
    '{ACT_REQ, bffa_pkg::KIND_ALLOC, 14'd5461, 1'b1, 14'd0, bffa_pkg::STATUS_FULL, 14'd0},
    '{ACT_REQ, bffa_pkg::KIND_RELEASE, 14'd2, 1'b1, 14'd0, bffa_pkg::STATUS_RANGE, 14'd0},
    '{ACT_REQ, bffa_pkg::KIND_RELEASE, 14'd1, 1'b1, 14'd0, bffa_pkg::STATUS_OK, 14'd1},
    '{ACT_CFG, bffa_pkg::KIND_ALLOC, 14'd0, 1'b0, 14'd0, bffa_pkg::STATUS_OK, 14'd0},
    '{ACT_REQ, bffa_pkg::KIND_ALLOC, 14'd0, 1'b1, 14'd0, bffa_pkg::STATUS_FULL, 14'd0},
    '{ACT_REQ, bffa_pkg::KIND_RELEASE, 14'd1, 1'b1, 14'd0, bffa_pkg::STATUS_RANGE, 14'd0},
    '{ACT_REQ, bffa_pkg::KIND_RELEASE, 14'd0, 1'b1, 14'd0, bffa_pkg::STATUS_RANGE, 14'd0},
    '{ACT_CFG, bffa_pkg::KIND_ALLOC, 14'd16383, 1'b0, 14'd0, bffa_pkg::STATUS_OK, 14'd0},
    '{ACT_REQ, bffa_pkg::KIND_ALLOC, 14'd0, 1'b1, 14'd1, bffa_pkg::STATUS_OK, 14'd8191},
    '{ACT_REQ, bffa_pkg::KIND_RELEASE, 14'd8192, 1'b1, 14'd0, bffa_pkg::STATUS_ALREADY_FREE,
      14'd8191},
    '{ACT_REQ, bffa_pkg::KIND_RELEASE, 14'd8193, 1'b1, 14'd0, bffa_pkg::STATUS_RANGE,
      14'd8191},
    '{ACT_CFG, bffa_pkg::KIND_ALLOC, 14'd3, 1'b0, 14'd0, bffa_pkg::STATUS_OK, 14'd0},
    '{ACT_REQ, bffa_pkg::KIND_ALLOC, 14'd10922, 1'b0, 14'd0, bffa_pkg::STATUS_OK, 14'd0},
    '{ACT_REQ, bffa_pkg::KIND_ALLOC, 14'd0, 1'b0, 14'd0, bffa_pkg::STATUS_OK, 14'd0},
    '{ACT_REQ, bffa_pkg::KIND_ALLOC, 14'd0, 1'b0, 14'd0, bffa_pkg::STATUS_OK, 14'd0},
    '{ACT_REQ, bffa_pkg::KIND_ALLOC, 14'd0, 1'b1, 14'd0, bffa_pkg::STATUS_FULL, 14'd0},
    '{ACT_REQ, bffa_pkg::KIND_RELEASE, 14'd2, 1'b0, 14'd0, bffa_pkg::STATUS_OK, 14'd0},
    '{ACT_REQ, bffa_pkg::KIND_ALLOC, 14'd0, 1'b0, 14'd0, bffa_pkg::STATUS_OK, 14'd0}
  };

  int ph_pool  [NUM_PH] = '{8, 1, 0, 5, 64, 127, 128, 129, 16383, 8192, 8191, 40, 2, 13};
  int ph_count [NUM_PH] = '{50, 30, 20, 50, 90, 60, 60, 140, 40, 125, 30, 60, 30, 40};
  int ph_alloc [NUM_PH] = '{60, 60, 50, 60, 70, 70, 70, 85, 60, 92, 50, 60, 50, 60};

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic note_mismatch(input string what);
    errors++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  task automatic format_pool(input int unsigned value);
    int i;
    pool_n = (value > MAP_DEPTH) ? MAP_DEPTH : int'(value);
    for (i = 0; i < MAP_DEPTH; i++) used_bits[i] = 1'b0;
    free_n = pool_n;
    held.delete();
  endtask

  function automatic answer_t bitmap_answer(input logic kind,
                                            input logic [bffa_pkg::NUM_W-1:0] num);
    answer_t a;
    int i;
    int k;
    a.granted = '0;
    a.status = bffa_pkg::STATUS_OK;
    if (kind == bffa_pkg::KIND_ALLOC) begin
      a.status = bffa_pkg::STATUS_FULL;
      for (i = 0; i < pool_n; i++) begin
        if (!used_bits[i]) begin
          used_bits[i] = 1'b1;
          if (free_n > 0) free_n--;
          a.granted = bffa_pkg::NUM_W'(i + 1);
          a.status = bffa_pkg::STATUS_OK;
          held.push_back(i + 1);
          break;
        end
      end
    end else if (num == 0 || int'(num) > pool_n) begin
      a.status = bffa_pkg::STATUS_RANGE;
    end else if (!used_bits[num - 1]) begin
      a.status = bffa_pkg::STATUS_ALREADY_FREE;
    end else begin
      used_bits[num - 1] = 1'b0;
      if (free_n < pool_n) free_n++;
      for (k = 0; k < held.size(); k++) begin
        if (held[k] == int'(num)) begin
          held.delete(k);
          break;
        end
      end
    end
    a.free_left = bffa_pkg::NUM_W'(free_n);
    return a;
  endfunction

  task automatic issue(input logic kind, input logic [bffa_pkg::NUM_W-1:0] num,
                       input logic typed, input answer_t typed_ans);
    answer_t a;
    req_ch.valid <= 1'b1;
    req_ch.kind <= kind;
    req_ch.entry_number <= num;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    a = bitmap_answer(kind, num);
    answers_due.push_back(typed ? typed_ans : a);
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 99) < 15) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic program_pool(input int unsigned value);
    logic [bffa_pkg::NUM_W-1:0] back;
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= ENTRIES_ADDR;
    cfg_pwdata <= bffa_pkg::CFG_DW'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    format_pool(value);
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    back = cfg_prdata[bffa_pkg::NUM_W-1:0];
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (back !== bffa_pkg::NUM_W'(value))
      note_mismatch($sformatf("pool size read back %0d, wrote %0d", back, value));
  endtask

  // Response side: random back-pressure bursts plus one long hold requested by the sender.
  initial begin
    int gap_left;
    int hold_left;
    gap_left = 0;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rsp) begin
        hold_rsp = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 12) begin
        gap_left = $urandom_range(1, 9) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      got.granted = rsp_ch.granted_number;
      got.status = bffa_pkg::status_t'(rsp_ch.status);
      got.free_left = rsp_ch.free_left;
      if (answers_due.size() == 0) begin
        note_mismatch($sformatf("unexpected transaction granted=%0d status=%0d free=%0d",
                                got.granted, got.status, got.free_left));
      end else begin
        want = answers_due.pop_front();
        if (got.granted !== want.granted || got.status !== want.status ||
            got.free_left !== want.free_left)
          note_mismatch($sformatf("granted=%0d status=%0d free=%0d, want %0d/%0d/%0d",
                                  got.granted, got.status, got.free_left,
                                  want.granted, want.status, want.free_left));
      end
    end
  end

  initial begin
    int p;
    int n;
    int r;
    logic kind;
    logic [bffa_pkg::NUM_W-1:0] num;
    answer_t typed_ans;
    rst_n <= 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.kind <= bffa_pkg::KIND_ALLOC;
    req_ch.entry_number <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    format_pool(bffa_pkg::ENTRIES_RST);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < NUM_DIR; n++) begin
      if (dir_tab[n].act == ACT_CFG) begin
        program_pool(dir_tab[n].num);
      end else begin
        typed_ans.granted = dir_tab[n].g;
        typed_ans.status = dir_tab[n].st;
        typed_ans.free_left = dir_tab[n].fl;
        sender_gap();
        issue(dir_tab[n].kind, dir_tab[n].num, dir_tab[n].typed, typed_ans);
      end
    end

    typed_ans = '0;
    for (p = 0; p < NUM_PH; p++) begin
      if (p >= QUIET_FROM) quiet = 1'b1;
      program_pool(ph_pool[p]);
      for (n = 0; n < ph_count[p]; n++) begin
        if (p == PRESS_PH && n == 10) hold_rsp = 1'b1;
        if (p == PRESS_PH && n == 40) begin
          req_ch.valid <= 1'b0;
          @(posedge clk);
          while (answers_due.size() != 0) @(posedge clk);
          @(posedge clk);
        end
        r = $urandom_range(0, 99);
        if (r < ph_alloc[p]) begin
          kind = bffa_pkg::KIND_ALLOC;
          num = bffa_pkg::NUM_W'($urandom);
        end else begin
          kind = bffa_pkg::KIND_RELEASE;
          r = $urandom_range(0, 99);
          if (r < 70 && held.size() != 0) begin
            num = bffa_pkg::NUM_W'(held[$urandom_range(0, held.size() - 1)]);
          end else if (r < 85 && pool_n != 0) begin
            num = bffa_pkg::NUM_W'($urandom_range(1, pool_n));
          end else begin
            case ($urandom_range(0, 2))
              0: num = '0;
              1: num = bffa_pkg::NUM_W'(pool_n + 1);
              default: num = bffa_pkg::NUM_W'($urandom);
            endcase
          end
        end
        sender_gap();
        issue(kind, num, 1'b0, typed_ans);
      end
    end

    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
